### design/sg4_pkg.sv
package sg4_pkg;

  localparam int FRAC_BITS = 40;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] LIM = 64'sd4611686018427387903;
  localparam logic signed [63:0] MU1 = 64'sd46179488367;
  localparam logic signed [63:0] MU2 = 64'sd239693534855;
  localparam logic signed [63:0] K1 = 64'sd616042268740;
  localparam logic signed [63:0] K2 = 64'sd267965079992;
  localparam logic signed [63:0] TWO_ONE = 64'sd2 * ONE;
  localparam logic signed [63:0] SIX_ONE = 64'sd6 * ONE;
  localparam logic signed [63:0] F_BASE = ONE + K1 + K2;
  localparam logic [31:0] SCALE_RESET = 32'd550950842;

  // highest derivative order requested
  localparam logic [1:0] CMD_VALUE = 2'd0;
  localparam logic [1:0] CMD_D1 = 2'd1;
  localparam logic [1:0] CMD_D2 = 2'd2;
  localparam logic [1:0] CMD_D3 = 2'd3;

  // register index taken from the word address
  localparam logic REG_SCALE = 1'b0;

  // accept edge to the edge that takes the result
  localparam int OUT_LAT = 110;

  typedef struct packed {
    logic       vld;
    logic [1:0] cmd;
  } tag_t;

  // truncating q.40 quotient of two positive constants
  function automatic logic signed [63:0] div_const(input logic [63:0] n,
                                                   input logic [63:0] d);
    logic [127:0] num;
    logic [127:0] rem;
    logic [127:0] q;
    num = {64'd0, n} << FRAC_BITS;
    rem = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      q = q << 1;
      if (rem >= {64'd0, d}) begin
        rem = rem - {64'd0, d};
        q[0] = 1'b1;
      end
    end
    return q[63:0];
  endfunction

  localparam logic signed [63:0] C1 = div_const(MU1, K1);
  localparam logic signed [63:0] C2 = div_const(MU2, K2);
  localparam logic signed [63:0] C1X2 = 64'sd2 * C1;
  localparam logic signed [63:0] C2X2 = 64'sd2 * C2;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > LIM) r = LIM;
    if (v < -LIM) r = -LIM;
    return r;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [64:0] s;
    logic signed [63:0] r;
    sa = sat64(a);
    sb = sat64(b);
    s = {sa[63], sa} + {sb[63], sb};
    r = s[63:0];
    if (s > 65'sd4611686018427387903) r = LIM;
    if (s < -65'sd4611686018427387903) r = -LIM;
    return r;
  endfunction

  function automatic logic [47:0] out48(input logic signed [63:0] v);
    logic [47:0] r;
    r = v[47:0];
    if (v > 64'sh0000_7fff_ffff_ffff) r = 48'h7fff_ffff_ffff;
    if (v < -64'sh0000_8000_0000_0000) r = 48'h8000_0000_0000;
    return r;
  endfunction

endpackage

### design/sg4_exchange_enhancement_unit.sv
// Computes the fourth-order semiclassical exchange enhancement factor and up to
// three of its derivatives for each transaction. A new transaction is taken in
// every clock cycle (busy stays low); each result appears on the out_ ports for
// one cycle with out_strobe high, in the order the transactions came in. The
// latency is set by two chained rounds of long division (32 stages each: an
// operand stage, then two quotient bits per stage) for 1/a and the polynomial
// ratios, plus the 3-stage multipliers of the derivative chain. The receiver
// cannot stall, so results must be taken when strobed.
module sg4_exchange_enhancement_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_grad_x,
  output logic        out_strobe,
  output logic [47:0] out_enhancement,
  output logic [47:0] out_first_deriv,
  output logic [47:0] out_second_deriv,
  output logic [47:0] out_third_deriv,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] scale_r;
  logic        in_vld_r;
  logic [1:0]  in_cmd_r;
  logic signed [63:0] xq_r, sq_r;
  sg4_pkg::tag_t tag_dl [108];

  logic signed [63:0] s, ss, t, ssx, a, a1, a2, b, b1, b2;
  logic signed [63:0] bp1_r, zdiv, hb, a1sq, a1a2, cubea;
  logic signed [63:0] z_r, z2, z3, z4;
  logic               le_r;
  logic signed [63:0] den_r, hn_r, n1_r, n2_r, n3_r;
  logic signed [63:0] h, g1, g2, g3;
  logic signed [63:0] r1, r2a, r2b, r3a, r3b, g2x3_r, r2_r, r2_d_r, r3a_r, r3_r;
  logic signed [63:0] rb1, rb2;
  logic signed [63:0] da0, da1, da2, da3, db0, db1, db2, db3;
  logic signed [63:0] ma0, ma1, ma2, ma3, mb0, mb1, mb2, mb3;
  logic signed [63:0] res0_r, res1_r, res2_r, res3_r;
  logic        out_strobe_r;
  logic [47:0] out_f_r, out_d1_r, out_d2_r, out_d3_r;

  logic signed [63:0] sq_dl [3];
  logic signed [63:0] ss_dl [3];
  logic signed [63:0] a_dl [32];
  logic signed [63:0] b1_dl [33];
  logic signed [63:0] b2_dl [33];
  logic signed [63:0] a1_dl [75];
  logic signed [63:0] a2_dl [75];
  logic signed [63:0] a1sq_dl [72];
  logic signed [63:0] cubea_dl [69];
  logic signed [63:0] a1a2_dl [73];
  logic signed [63:0] z_dl [9];
  logic signed [63:0] z2_dl [6];
  logic signed [63:0] z3_dl [3];
  logic               le_dl [9];
  logic signed [63:0] h_dl [5];
  logic signed [63:0] r1_dl [2];
  logic signed [63:0] hb_dl [3];
  logic signed [63:0] db0_dl [44];
  logic signed [63:0] db1_dl [44];
  logic signed [63:0] db2_dl [44];
  logic signed [63:0] db3_dl [44];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sg4_pkg::REG_SCALE) ? scale_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= sg4_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == sg4_pkg::REG_SCALE) begin
      scale_r <= pwdata;
    end
  end

  assign busy = 1'b0;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_cmd_r <= in_cmd;
    xq_r <= $signed({16'd0, in_grad_x, 16'd0});
    sq_r <= $signed({24'd0, scale_r, 8'd0});
  end

  // s, t = s^2 and the chain-rule factors
  sg4_mulq u_s (.clk(clk), .a(sq_r), .b(xq_r), .p(s));
  sg4_mulq u_ss (.clk(clk), .a(sq_r), .b(sq_r), .p(ss));
  sg4_mulq u_t (.clk(clk), .a(s), .b(s), .p(t));
  sg4_mulq u_ssx (.clk(clk), .a(s), .b(sq_dl[2]), .p(ssx));
  sg4_mulq u_a (.clk(clk), .a(sg4_pkg::C1), .b(t), .p(a));
  sg4_mulq u_a1 (.clk(clk), .a(sg4_pkg::C1X2), .b(ssx), .p(a1));
  sg4_mulq u_a2 (.clk(clk), .a(sg4_pkg::C1X2), .b(ss_dl[2]), .p(a2));
  sg4_mulq u_b (.clk(clk), .a(sg4_pkg::C2), .b(t), .p(b));
  sg4_mulq u_b1 (.clk(clk), .a(sg4_pkg::C2X2), .b(ssx), .p(b1));
  sg4_mulq u_b2 (.clk(clk), .a(sg4_pkg::C2X2), .b(ss_dl[2]), .p(b2));

  sg4_mulq u_a1sq (.clk(clk), .a(a1), .b(a1), .p(a1sq));
  sg4_mulq u_a1a2 (.clk(clk), .a(a1), .b(a2), .p(a1a2));
  sg4_mulq u_cubea (.clk(clk), .a(a1sq), .b(a1_dl[2]), .p(cubea));

  // 1/a for the large-a branch, 1/(1+b) for the second term
  sg4_divq u_za (.clk(clk), .n(sg4_pkg::ONE), .d(a), .q(zdiv));

  always_ff @(posedge clk) begin
    bp1_r <= sg4_pkg::sadd(sg4_pkg::ONE, b);
  end

  sg4_divq u_hb (.clk(clk), .n(sg4_pkg::ONE), .d(bp1_r), .q(hb));

  always_ff @(posedge clk) begin
    le_r <= a_dl[31] <= sg4_pkg::ONE;
    if (a_dl[31] <= sg4_pkg::ONE) z_r <= a_dl[31][63] ? 64'sd0 : a_dl[31];
    else z_r <= zdiv;
  end

  sg4_mulq u_z2 (.clk(clk), .a(z_r), .b(z_r), .p(z2));
  sg4_mulq u_z3 (.clk(clk), .a(z2), .b(z_dl[2]), .p(z3));
  sg4_mulq u_z4 (.clk(clk), .a(z3), .b(z_dl[5]), .p(z4));

  // numerators and shared denominator of the polynomial ratios, plain wrapping sums
  always_ff @(posedge clk) begin
    den_r <= sg4_pkg::ONE + z_dl[8] + z2_dl[5] + z3_dl[2] + z4;
    if (le_dl[8]) begin
      hn_r <= sg4_pkg::ONE;
      n1_r <= sg4_pkg::ONE + 64'sd2 * z_dl[8] + 64'sd3 * z2_dl[5] + 64'sd4 * z3_dl[2];
      n2_r <= sg4_pkg::TWO_ONE + 64'sd6 * z_dl[8] + 64'sd12 * z2_dl[5];
      n3_r <= sg4_pkg::SIX_ONE + 64'sd24 * z_dl[8];
    end else begin
      hn_r <= z4;
      n1_r <= 64'sd4 * z_dl[8] + 64'sd3 * z2_dl[5] + 64'sd2 * z3_dl[2] + z4;
      n2_r <= 64'sd12 * z2_dl[5] + 64'sd6 * z3_dl[2] + 64'sd2 * z4;
      n3_r <= 64'sd24 * z3_dl[2] + 64'sd6 * z4;
    end
  end

  sg4_divq u_h (.clk(clk), .n(hn_r), .d(den_r), .q(h));
  sg4_divq u_g1 (.clk(clk), .n(n1_r), .d(den_r), .q(g1));
  sg4_divq u_g2 (.clk(clk), .n(n2_r), .d(den_r), .q(g2));
  sg4_divq u_g3 (.clk(clk), .n(n3_r), .d(den_r), .q(g3));

  // ratios of the first denominator taken to x
  sg4_mulq u_r1 (.clk(clk), .a(g1), .b(a1_dl[74]), .p(r1));
  sg4_mulq u_r2a (.clk(clk), .a(g2), .b(a1sq_dl[71]), .p(r2a));
  sg4_mulq u_r2b (.clk(clk), .a(g1), .b(a2_dl[74]), .p(r2b));
  sg4_mulq u_r3a (.clk(clk), .a(g3), .b(cubea_dl[68]), .p(r3a));
  sg4_mulq u_r3b (.clk(clk), .a(g2x3_r), .b(a1a2_dl[72]), .p(r3b));

  always_ff @(posedge clk) begin
    g2x3_r <= 64'sd3 * g2;
    r2_r <= sg4_pkg::sadd(r2a, r2b);
    r2_d_r <= r2_r;
    r3a_r <= r3a;
    r3_r <= sg4_pkg::sadd(r3a_r, r3b);
  end

  sg4_rcpd u_rcpd_a (
    .clk(clk), .h(h_dl[4]), .r1(r1_dl[1]), .r2(r2_d_r), .r3(r3_r),
    .d0(da0), .d1(da1), .d2(da2), .d3(da3)
  );

  sg4_mulq u_rb1 (.clk(clk), .a(b1_dl[32]), .b(hb), .p(rb1));
  sg4_mulq u_rb2 (.clk(clk), .a(b2_dl[32]), .b(hb), .p(rb2));

  sg4_rcpd u_rcpd_b (
    .clk(clk), .h(hb_dl[2]), .r1(rb1), .r2(rb2), .r3(64'sd0),
    .d0(db0), .d1(db1), .d2(db2), .d3(db3)
  );

  sg4_mulq u_ma0 (.clk(clk), .a(sg4_pkg::K1), .b(da0), .p(ma0));
  sg4_mulq u_ma1 (.clk(clk), .a(sg4_pkg::K1), .b(da1), .p(ma1));
  sg4_mulq u_ma2 (.clk(clk), .a(sg4_pkg::K1), .b(da2), .p(ma2));
  sg4_mulq u_ma3 (.clk(clk), .a(sg4_pkg::K1), .b(da3), .p(ma3));
  sg4_mulq u_mb0 (.clk(clk), .a(sg4_pkg::K2), .b(db0_dl[43]), .p(mb0));
  sg4_mulq u_mb1 (.clk(clk), .a(sg4_pkg::K2), .b(db1_dl[43]), .p(mb1));
  sg4_mulq u_mb2 (.clk(clk), .a(sg4_pkg::K2), .b(db2_dl[43]), .p(mb2));
  sg4_mulq u_mb3 (.clk(clk), .a(sg4_pkg::K2), .b(db3_dl[43]), .p(mb3));

  always_ff @(posedge clk) begin
    res0_r <= sg4_pkg::sadd(sg4_pkg::sadd(sg4_pkg::F_BASE, -ma0), -mb0);
    res1_r <= sg4_pkg::sadd(-ma1, -mb1);
    res2_r <= sg4_pkg::sadd(-ma2, -mb2);
    res3_r <= sg4_pkg::sadd(-ma3, -mb3);
  end

  // output register, unrequested orders forced to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tag_dl[107].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_f_r <= sg4_pkg::out48(res0_r);
    out_d1_r <= (tag_dl[107].cmd >= sg4_pkg::CMD_D1) ? sg4_pkg::out48(res1_r) : 48'd0;
    out_d2_r <= (tag_dl[107].cmd >= sg4_pkg::CMD_D2) ? sg4_pkg::out48(res2_r) : 48'd0;
    out_d3_r <= (tag_dl[107].cmd >= sg4_pkg::CMD_D3) ? sg4_pkg::out48(res3_r) : 48'd0;
  end

  assign out_strobe = out_strobe_r;
  assign out_enhancement = out_f_r;
  assign out_first_deriv = out_d1_r;
  assign out_second_deriv = out_d2_r;
  assign out_third_deriv = out_d3_r;

  // transaction tags travel alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 108; i++) tag_dl[i].vld <= 1'b0;
    end else begin
      tag_dl[0].vld <= in_vld_r;
      for (int i = 1; i < 108; i++) tag_dl[i].vld <= tag_dl[i-1].vld;
    end
    tag_dl[0].cmd <= in_cmd_r;
    for (int i = 1; i < 108; i++) tag_dl[i].cmd <= tag_dl[i-1].cmd;
  end

  // alignment delay lines
  always_ff @(posedge clk) begin
    sq_dl[0] <= sq_r;
    for (int i = 1; i < 3; i++) sq_dl[i] <= sq_dl[i-1];
    ss_dl[0] <= ss;
    for (int i = 1; i < 3; i++) ss_dl[i] <= ss_dl[i-1];
    a_dl[0] <= a;
    for (int i = 1; i < 32; i++) a_dl[i] <= a_dl[i-1];
    b1_dl[0] <= b1;
    b2_dl[0] <= b2;
    for (int i = 1; i < 33; i++) begin
      b1_dl[i] <= b1_dl[i-1];
      b2_dl[i] <= b2_dl[i-1];
    end
    a1_dl[0] <= a1;
    a2_dl[0] <= a2;
    for (int i = 1; i < 75; i++) begin
      a1_dl[i] <= a1_dl[i-1];
      a2_dl[i] <= a2_dl[i-1];
    end
    a1sq_dl[0] <= a1sq;
    for (int i = 1; i < 72; i++) a1sq_dl[i] <= a1sq_dl[i-1];
    cubea_dl[0] <= cubea;
    for (int i = 1; i < 69; i++) cubea_dl[i] <= cubea_dl[i-1];
    a1a2_dl[0] <= a1a2;
    for (int i = 1; i < 73; i++) a1a2_dl[i] <= a1a2_dl[i-1];
    z_dl[0] <= z_r;
    le_dl[0] <= le_r;
    for (int i = 1; i < 9; i++) begin
      z_dl[i] <= z_dl[i-1];
      le_dl[i] <= le_dl[i-1];
    end
    z2_dl[0] <= z2;
    for (int i = 1; i < 6; i++) z2_dl[i] <= z2_dl[i-1];
    z3_dl[0] <= z3;
    for (int i = 1; i < 3; i++) z3_dl[i] <= z3_dl[i-1];
    h_dl[0] <= h;
    for (int i = 1; i < 5; i++) h_dl[i] <= h_dl[i-1];
    r1_dl[0] <= r1;
    r1_dl[1] <= r1_dl[0];
    hb_dl[0] <= hb;
    for (int i = 1; i < 3; i++) hb_dl[i] <= hb_dl[i-1];
    db0_dl[0] <= db0;
    db1_dl[0] <= db1;
    db2_dl[0] <= db2;
    db3_dl[0] <= db3;
    for (int i = 1; i < 44; i++) begin
      db0_dl[i] <= db0_dl[i-1];
      db1_dl[i] <= db1_dl[i-1];
      db2_dl[i] <= db2_dl[i-1];
      db3_dl[i] <= db3_dl[i-1];
    end
  end

  // a strobe only ever follows an accepted transaction
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, sg4_pkg::OUT_LAT))
    else $error("result strobe without a matching transaction");

  // zero gradient gives exactly one and a zero first derivative
  a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_grad_x == 32'd0, sg4_pkg::OUT_LAT)
    |-> out_enhancement == 48'(sg4_pkg::ONE) && out_first_deriv == 48'd0)
    else $error("zero gradient did not give unit enhancement");

  // value-only request leaves every derivative at zero
  a_order_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_cmd == sg4_pkg::CMD_VALUE, sg4_pkg::OUT_LAT)
    |-> out_first_deriv == 48'd0 && out_second_deriv == 48'd0
        && out_third_deriv == 48'd0)
    else $error("unrequested derivative not zero");

endmodule

### design/sg4_mulq.sv
module sg4_mulq (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic        neg1_r, neg2_r;
  logic [127:0] prod_r;
  logic [63:0] mag;
  logic signed [63:0] p_r;

  assign ua = a[63] ? (64'd0 - a) : a;
  assign ub = b[63] ? (64'd0 - b) : b;

  always_ff @(posedge clk) begin
    p00_r <= ua[31:0] * ub[31:0];
    p01_r <= ua[31:0] * ub[63:32];
    p10_r <= ua[63:32] * ub[31:0];
    p11_r <= ua[63:32] * ub[63:32];
    neg1_r <= a[63] ^ b[63];
  end

  // full product plus half an lsb of the result
  always_ff @(posedge clk) begin
    prod_r <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
              + {p11_r, 64'd0} + (128'd1 << (sg4_pkg::FRAC_BITS - 1));
    neg2_r <= neg1_r;
  end

  assign mag = (prod_r[127:102] != '0) ? sg4_pkg::LIM : {2'b00, prod_r[101:40]};

  always_ff @(posedge clk) begin
    p_r <= neg2_r ? -$signed(mag) : $signed(mag);
  end

  assign p = p_r;

endmodule

### design/sg4_divq.sv
module sg4_divq (
  input  logic               clk,
  input  logic signed [63:0] n,
  input  logic signed [63:0] d,
  output logic signed [63:0] q
);

  localparam logic [1:0] SPEC_NONE = 2'd0;
  localparam logic [1:0] SPEC_ZERO = 2'd1;
  localparam logic [1:0] SPEC_LIM = 2'd2;

  logic [61:0] un, ud;
  logic        ovf;
  logic [1:0]  spec;
  logic [61:0] rem_r [32];
  logic [61:0] bits_r [32];
  logic [61:0] ud_r [32];
  logic [61:0] q_r [32];
  logic [1:0]  spec_r [32];
  logic [61:0] rem_nxt [1:31];
  logic [61:0] bits_nxt [1:31];
  logic [61:0] q_nxt [1:31];

  assign un = (n[63:62] != 2'b00) ? sg4_pkg::LIM[61:0] : n[61:0];
  assign ud = (d[63:62] != 2'b00) ? sg4_pkg::LIM[61:0] : d[61:0];
  assign ovf = {22'd0, un} >= {ud, 22'd0};

  always_comb begin
    if (d[63] || d == '0) spec = SPEC_LIM;
    else if (n[63] || n == '0) spec = SPEC_ZERO;
    else if (ovf) spec = SPEC_LIM;
    else spec = SPEC_NONE;
  end

  // two quotient bits per stage
  always_comb begin
    logic [61:0] r;
    logic [61:0] bb;
    logic [61:0] qq;
    logic [62:0] t;
    for (int k = 1; k < 32; k++) begin
      r = rem_r[k-1];
      bb = bits_r[k-1];
      qq = q_r[k-1];
      for (int j = 0; j < 2; j++) begin
        t = {r, bb[61]};
        bb = bb << 1;
        qq = qq << 1;
        if (t >= {1'b0, ud_r[k-1]}) begin
          t = t - {1'b0, ud_r[k-1]};
          qq[0] = 1'b1;
        end
        r = t[61:0];
      end
      rem_nxt[k] = r;
      bits_nxt[k] = bb;
      q_nxt[k] = qq;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {22'd0, un[61:22]};
    bits_r[0] <= {un[21:0], 40'd0};
    ud_r[0] <= ud;
    q_r[0] <= '0;
    spec_r[0] <= spec;
    for (int k = 1; k < 32; k++) begin
      rem_r[k] <= rem_nxt[k];
      bits_r[k] <= bits_nxt[k];
      q_r[k] <= q_nxt[k];
      ud_r[k] <= ud_r[k-1];
      spec_r[k] <= spec_r[k-1];
    end
  end

  always_comb begin
    case (spec_r[31])
      SPEC_LIM:  q = sg4_pkg::LIM;
      SPEC_ZERO: q = '0;
      default:   q = $signed({2'b00, q_r[31]});
    endcase
  end

endmodule

### design/sg4_rcpd.sv
module sg4_rcpd (
  input  logic               clk,
  input  logic signed [63:0] h,
  input  logic signed [63:0] r1,
  input  logic signed [63:0] r2,
  input  logic signed [63:0] r3,
  output logic signed [63:0] d0,
  output logic signed [63:0] d1,
  output logic signed [63:0] d2,
  output logic signed [63:0] d3
);

  logic signed [63:0] h1_r, r1_r, r2_r, nr1_r, nr2_r, nr3_r;
  logic signed [63:0] r1sq, d1_m, r1r2, p2, cube, p6a, p6b, d2_m, d3_m;
  logic signed [63:0] s2_r, t3_r, u3_r;
  logic signed [63:0] h_dl [14];
  logic signed [63:0] r1_dl [3];
  logic signed [63:0] nr2_dl [6];
  logic signed [63:0] nr3_dl [10];
  logic signed [63:0] p6a_dl [3];
  logic signed [63:0] d1_dl [11];
  logic signed [63:0] d2_dl [4];

  always_ff @(posedge clk) begin
    h1_r <= h;
    r1_r <= r1;
    r2_r <= r2;
    nr1_r <= -sg4_pkg::sat64(r1);
    nr2_r <= -sg4_pkg::sat64(r2);
    nr3_r <= -sg4_pkg::sat64(r3);
  end

  sg4_mulq u_r1sq (.clk(clk), .a(r1_r), .b(r1_r), .p(r1sq));
  sg4_mulq u_d1 (.clk(clk), .a(h1_r), .b(nr1_r), .p(d1_m));
  sg4_mulq u_r1r2 (.clk(clk), .a(r1_r), .b(r2_r), .p(r1r2));
  sg4_mulq u_p2 (.clk(clk), .a(sg4_pkg::TWO_ONE), .b(r1sq), .p(p2));
  sg4_mulq u_cube (.clk(clk), .a(r1sq), .b(r1_dl[2]), .p(cube));
  sg4_mulq u_p6a (.clk(clk), .a(sg4_pkg::SIX_ONE), .b(r1r2), .p(p6a));
  sg4_mulq u_p6b (.clk(clk), .a(sg4_pkg::SIX_ONE), .b(cube), .p(p6b));
  sg4_mulq u_d2 (.clk(clk), .a(h_dl[6]), .b(s2_r), .p(d2_m));
  sg4_mulq u_d3 (.clk(clk), .a(h_dl[10]), .b(u3_r), .p(d3_m));

  always_ff @(posedge clk) begin
    s2_r <= sg4_pkg::sadd(p2, nr2_dl[5]);
    t3_r <= sg4_pkg::sadd(p6a_dl[2], -p6b);
    u3_r <= sg4_pkg::sadd(t3_r, nr3_dl[9]);
  end

  always_ff @(posedge clk) begin
    h_dl[0] <= h1_r;
    for (int i = 1; i < 14; i++) h_dl[i] <= h_dl[i-1];
    r1_dl[0] <= r1_r;
    for (int i = 1; i < 3; i++) r1_dl[i] <= r1_dl[i-1];
    nr2_dl[0] <= nr2_r;
    for (int i = 1; i < 6; i++) nr2_dl[i] <= nr2_dl[i-1];
    nr3_dl[0] <= nr3_r;
    for (int i = 1; i < 10; i++) nr3_dl[i] <= nr3_dl[i-1];
    p6a_dl[0] <= p6a;
    for (int i = 1; i < 3; i++) p6a_dl[i] <= p6a_dl[i-1];
    d1_dl[0] <= d1_m;
    for (int i = 1; i < 11; i++) d1_dl[i] <= d1_dl[i-1];
    d2_dl[0] <= d2_m;
    for (int i = 1; i < 4; i++) d2_dl[i] <= d2_dl[i-1];
  end

  assign d0 = h_dl[13];
  assign d1 = d1_dl[10];
  assign d2 = d2_dl[3];
  assign d3 = d3_m;

endmodule

### tb/sg4_exchange_enhancement_checker.sv
`timescale 1ns / 1ps
module sg4_exchange_enhancement_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_grad_x,
  input  logic        out_strobe,
  input  logic [47:0] out_enhancement,
  input  logic [47:0] out_first_deriv,
  input  logic [47:0] out_second_deriv,
  input  logic [47:0] out_third_deriv,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic [47:0] f;
    logic [47:0] d1;
    logic [47:0] d2;
    logic [47:0] d3;
  } factor_t;

  factor_t    expected_factors[$];
  logic [31:0] s_scale;

  function automatic logic signed [63:0] clamp62(input logic signed [64:0] v);
    if (v > 65'sd4611686018427387903) return sg4_pkg::LIM;
    if (v < -65'sd4611686018427387903) return -sg4_pkg::LIM;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] ca;
    logic signed [63:0] cb;
    ca = clamp62({a[63], a});
    cb = clamp62({b[63], b});
    return clamp62({ca[63], ca} + {cb[63], cb});
  endfunction

  // round to nearest, ties away from zero, magnitude capped
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  r;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << 39)) >> 40;
    r = (p > 128'(sg4_pkg::LIM)) ? sg4_pkg::LIM : p[63:0];
    return (a[63] != b[63]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] n,
                                              input logic signed [63:0] d);
    logic [63:0]  un;
    logic [63:0]  ud;
    logic [127:0] q;
    if (d <= 0) return sg4_pkg::LIM;
    if (n <= 0) return 64'sd0;
    un = clamp62({n[63], n});
    ud = clamp62({d[63], d});
    if (un / ud >= 64'd4194304) return sg4_pkg::LIM;
    q = ({64'd0, un} << 40) / {64'd0, ud};
    return clamp62({1'b0, q[63:0]});
  endfunction

  function automatic logic [47:0] to48(input logic signed [63:0] v);
    if (v > 64'sh7fff_ffff_ffff) return 48'h7fff_ffff_ffff;
    if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
    return v[47:0];
  endfunction

  // 1/P(a) and P'/P, P''/P, P'''/P; large a is folded through z = 1/a
  function automatic void poly_ratios(input logic signed [63:0] a,
                                      output logic signed [63:0] h,
                                      output logic signed [63:0] g1,
                                      output logic signed [63:0] g2,
                                      output logic signed [63:0] g3);
    logic signed [63:0] z, z2, z3, z4, den, hn, n1, n2, n3;
    if (a <= sg4_pkg::ONE) begin
      z = a < 0 ? 64'sd0 : a;
      z2 = qmul(z, z); z3 = qmul(z2, z); z4 = qmul(z3, z);
      hn = sg4_pkg::ONE;
      n1 = sg4_pkg::ONE + 2 * z + 3 * z2 + 4 * z3;
      n2 = 2 * sg4_pkg::ONE + 6 * z + 12 * z2;
      n3 = 6 * sg4_pkg::ONE + 24 * z;
    end else begin
      z = qdiv(sg4_pkg::ONE, a);
      z2 = qmul(z, z); z3 = qmul(z2, z); z4 = qmul(z3, z);
      hn = z4;
      n1 = 4 * z + 3 * z2 + 2 * z3 + z4;
      n2 = 12 * z2 + 6 * z3 + 2 * z4;
      n3 = 24 * z3 + 6 * z4;
    end
    den = sg4_pkg::ONE + z + z2 + z3 + z4;
    h = qdiv(hn, den);
    g1 = qdiv(n1, den);
    g2 = qdiv(n2, den);
    g3 = qdiv(n3, den);
  endfunction

  function automatic void recip_chain(input logic signed [63:0] h,
                                      input logic signed [63:0] r1,
                                      input logic signed [63:0] r2,
                                      input logic signed [63:0] r3,
                                      output logic signed [63:0] d1,
                                      output logic signed [63:0] d2,
                                      output logic signed [63:0] d3);
    logic signed [63:0] r1sq, t3;
    r1sq = qmul(r1, r1);
    d1 = qmul(h, -clamp62({r1[63], r1}));
    d2 = qmul(h, qadd(qmul(2 * sg4_pkg::ONE, r1sq), -clamp62({r2[63], r2})));
    t3 = qadd(qmul(6 * sg4_pkg::ONE, qmul(r1, r2)),
              -qmul(6 * sg4_pkg::ONE, qmul(r1sq, r1)));
    d3 = qmul(h, qadd(t3, -clamp62({r3[63], r3})));
  endfunction

  function automatic factor_t predict_factor(input logic [1:0] order, input logic [31:0] gx,
                                             input logic [31:0] scale);
    logic signed [63:0] xq, sq, s, t, ss_x, ss, c1, c2;
    logic signed [63:0] a, a1, a2, a1sq, h, g1, g2, g3, r1, r2, r3;
    logic signed [63:0] b, b1, b2, hb, da1, da2, da3, db1, db2, db3, f;
    factor_t res;
    xq = {16'd0, gx, 16'd0};
    sq = {24'd0, scale, 8'd0};
    s = qmul(sq, xq);
    t = qmul(s, s);
    ss_x = qmul(s, sq);
    ss = qmul(sq, sq);
    c1 = qdiv(sg4_pkg::MU1, sg4_pkg::K1);
    c2 = qdiv(sg4_pkg::MU2, sg4_pkg::K2);
    a = qmul(c1, t);
    a1 = qmul(2 * c1, ss_x);
    a2 = qmul(2 * c1, ss);
    poly_ratios(a, h, g1, g2, g3);
    a1sq = qmul(a1, a1);
    r1 = qmul(g1, a1);
    r2 = qadd(qmul(g2, a1sq), qmul(g1, a2));
    r3 = qadd(qmul(g3, qmul(a1sq, a1)), qmul(3 * g2, qmul(a1, a2)));
    recip_chain(h, r1, r2, r3, da1, da2, da3);
    b = qmul(c2, t);
    b1 = qmul(2 * c2, ss_x);
    b2 = qmul(2 * c2, ss);
    hb = qdiv(sg4_pkg::ONE, qadd(sg4_pkg::ONE, b));
    recip_chain(hb, qmul(b1, hb), qmul(b2, hb), 64'sd0, db1, db2, db3);
    f = qadd(qadd(sg4_pkg::F_BASE, -qmul(sg4_pkg::K1, h)), -qmul(sg4_pkg::K2, hb));
    res.f = to48(f);
    res.d1 = (order >= sg4_pkg::CMD_D1) ?
             to48(qadd(-qmul(sg4_pkg::K1, da1), -qmul(sg4_pkg::K2, db1))) : 48'd0;
    res.d2 = (order >= sg4_pkg::CMD_D2) ?
             to48(qadd(-qmul(sg4_pkg::K1, da2), -qmul(sg4_pkg::K2, db2))) : 48'd0;
    res.d3 = (order >= sg4_pkg::CMD_D3) ?
             to48(qadd(-qmul(sg4_pkg::K1, da3), -qmul(sg4_pkg::K2, db3))) : 48'd0;
    return res;
  endfunction

  assign pending = expected_factors.size();

  always @(posedge clk) begin
    factor_t want;
    factor_t got;
    if (!rst_n) begin
      s_scale = sg4_pkg::SCALE_RESET;
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == sg4_pkg::REG_SCALE)
        s_scale = pwdata;
      if (start && !busy)
        expected_factors.push_back(predict_factor(in_cmd, in_grad_x, s_scale));
      if (out_strobe) begin
        got = {out_enhancement, out_first_deriv, out_second_deriv, out_third_deriv};
        if (expected_factors.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = expected_factors.pop_front();
          if (want != got) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: F exp %h got %h | d1 exp %h got %h | %s",
                       want.f, got.f, want.d1, got.d1,
                       $sformatf("d2 exp %h got %h | d3 exp %h got %h",
                                 want.d2, got.d2, want.d3, got.d3));
          end
        end
      end
    end
  end

endmodule

### tb/sg4_exchange_enhancement_unit_tb.sv
`timescale 1ns / 1ps
module sg4_exchange_enhancement_unit_tb;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [31:0] in_grad_x;
  logic        out_strobe;
  logic [47:0] out_enhancement;
  logic [47:0] out_first_deriv;
  logic [47:0] out_second_deriv;
  logic [47:0] out_third_deriv;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;
  int          cycles;

  sg4_exchange_enhancement_unit u_dut (.*);

  sg4_exchange_enhancement_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 300000) begin
        $display("sg4_exchange_enhancement_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_grad(input logic [1:0] c, input logic [31:0] g);
    start <= 1'b1;
    in_cmd <= c;
    in_grad_x <= g;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_scale(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random gradient: full range, the a ~ 1 region, or small values
  function automatic logic [31:0] pick_grad();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(32'h1000_0000, 32'h2800_0000);
      2: return $urandom_range(0, 32'h0800_0000);
      default: return $urandom_range(0, 32'h0000_ffff);
    endcase
  endfunction

  task automatic random_items(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if (burst > left) burst = left;
      repeat (burst)
        send_grad(2'($urandom_range(sg4_pkg::CMD_VALUE, sg4_pkg::CMD_D3)), pick_grad());
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  logic [31:0] scales[6];

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= sg4_pkg::CMD_VALUE;
    in_grad_x <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every order, zero x, the a = 1 crossing
    send_grad(sg4_pkg::CMD_D3, 32'd0);
    send_grad(sg4_pkg::CMD_VALUE, 32'd0);
    send_grad(sg4_pkg::CMD_D3, 32'd1);
    send_grad(sg4_pkg::CMD_D1, 32'hffff_ffff);
    send_grad(sg4_pkg::CMD_D2, 32'hffff_ffff);
    send_grad(sg4_pkg::CMD_D3, 32'hffff_ffff);
    send_grad(sg4_pkg::CMD_D3, 32'h1c80_0000);
    send_grad(sg4_pkg::CMD_D3, 32'h1c70_0000);
    send_grad(sg4_pkg::CMD_D3, 32'h1c90_0000);
    send_grad(sg4_pkg::CMD_D2, 32'h0100_0000);
    send_grad(sg4_pkg::CMD_D1, 32'h0400_0000);
    send_grad(sg4_pkg::CMD_VALUE, 32'h4000_0000);
    send_grad(sg4_pkg::CMD_D3, 32'haaaa_aaaa);
    send_grad(sg4_pkg::CMD_D3, 32'h5555_5555);
    send_grad(sg4_pkg::CMD_D3, 32'h8000_0000);
    drain();

    // hold-off until everything is out, then a zero scale
    write_scale(32'd0);
    send_grad(sg4_pkg::CMD_D3, 32'h1234_5678);
    send_grad(sg4_pkg::CMD_D3, 32'hffff_ffff);
    drain();

    scales[0] = 32'hffff_ffff;
    scales[1] = 32'd1;
    scales[2] = $urandom();
    scales[3] = $urandom();
    scales[4] = sg4_pkg::SCALE_RESET;
    scales[5] = 32'h8000_0000;
    for (int i = 0; i < 6; i++) begin
      write_scale(scales[i]);
      random_items(220);
      drain();
    end

    repeat (sg4_pkg::OUT_LAT + 20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("sg4_exchange_enhancement_unit regression: pass");
    end else begin
      $display("sg4_exchange_enhancement_unit regression: fail");
    end
    $finish;
  end

endmodule
